// ----- src/mbe_pkg.sv -----
package mbe_pkg;

  // Fixed-point format: signed Q16.32 in 48 bits
  localparam int Q_W    = 48;
  localparam int STEP_W = 47;
  localparam int MAG_W  = 47;
  localparam int FRAC_W = 32;
  localparam int HALF_W = 24;
  localparam int PROD_W = 96;
  localparam int SUM_W  = 51;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;

  // Register file layout
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int REG_LSB    = 3;

  localparam logic [REG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_MAX    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ESC_RSQ  = 3'd5;

  // Partial product selectors (low/high halves of a and b)
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HL = 2'd2;
  localparam logic [1:0] PART_HH = 2'd3;

  typedef logic signed [Q_W-1:0] q_t;

  typedef struct packed {
    q_t                x_min;
    logic [STEP_W-1:0] x_step;
    q_t                y_max;
    logic [STEP_W-1:0] y_step;
  } coord_cfg_t;

  typedef struct packed {
    q_t cr;
    q_t ci;
  } cpoint_t;

  typedef struct packed {
    logic       clear;
    logic       issue;
    logic [1:0] part;
  } mul_ctl_t;

  // Saturate a widened sum into the signed Q16.32 range
  function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-Q_W:0] top;
    top = v[SUM_W-1:Q_W-1];
    if (top == '0 || top == '1) begin
      sat_q = v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_q = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

  // Absolute value as unsigned; the most negative code maps to 2^47
  function automatic logic [Q_W-1:0] mag_q(input q_t v);
    logic [Q_W-1:0] u;
    u = v;
    mag_q = v[Q_W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

// ----- src/mbe_fifo.sv -----
module mbe_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbe_pkg::cpoint_t push_data,
  output logic             full,
  input  logic             pop,
  output mbe_pkg::cpoint_t head,
  output logic             empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  mbe_pkg::cpoint_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= PTR_W'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= PTR_W'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// ----- src/mbe_front.sv -----
module mbe_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_BITS-1:0]  in_column,
  input  logic [COORD_BITS-1:0]  in_row,
  input  mbe_pkg::coord_cfg_t    cfg,
  output logic                   push,
  output mbe_pkg::cpoint_t       push_data,
  input  logic                   q_full
);

  localparam int PW    = COORD_BITS + mbe_pkg::STEP_W;
  localparam int CL_W  = mbe_pkg::Q_W + 1;
  localparam logic [PW-1:0] CLAMP_LIM = {{(PW-CL_W){1'b0}}, 1'b1, {(CL_W-1){1'b0}}};

  logic          s1_vld_r;
  logic [PW-1:0] px_r;
  logic [PW-1:0] py_r;
  logic          accept;
  logic [CL_W-1:0] px_cl;
  logic [CL_W-1:0] py_cl;
  logic signed [mbe_pkg::SUM_W-1:0] cr_sum;
  logic signed [mbe_pkg::SUM_W-1:0] ci_sum;

  assign push     = s1_vld_r && !q_full;
  assign in_stall = s1_vld_r && q_full;
  assign accept   = in_valid && !in_stall;

  // Hold the offset products until the queue takes them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (push) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= PW'(in_column) * PW'(cfg.x_step);
      py_r <= PW'(in_row) * PW'(cfg.y_step);
    end
  end

  // Clamp offsets and map the pixel to c with saturation
  always_comb begin
    px_cl  = (px_r > CLAMP_LIM) ? CLAMP_LIM[CL_W-1:0] : px_r[CL_W-1:0];
    py_cl  = (py_r > CLAMP_LIM) ? CLAMP_LIM[CL_W-1:0] : py_r[CL_W-1:0];
    cr_sum = $signed({{(mbe_pkg::SUM_W-mbe_pkg::Q_W){cfg.x_min[mbe_pkg::Q_W-1]}}, cfg.x_min})
           + $signed({{(mbe_pkg::SUM_W-CL_W){1'b0}}, px_cl});
    ci_sum = $signed({{(mbe_pkg::SUM_W-mbe_pkg::Q_W){cfg.y_max[mbe_pkg::Q_W-1]}}, cfg.y_max})
           - $signed({{(mbe_pkg::SUM_W-CL_W){1'b0}}, py_cl});
    push_data.cr = mbe_pkg::sat_q(cr_sum);
    push_data.ci = mbe_pkg::sat_q(ci_sum);
  end

endmodule

// ----- src/mbe_qmul.sv -----
module mbe_qmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mbe_pkg::mul_ctl_t          ctl,
  input  logic [mbe_pkg::Q_W-1:0]    a_mag,
  input  logic [mbe_pkg::Q_W-1:0]    b_mag,
  output logic [mbe_pkg::MAG_W-1:0]  prod_sat
);

  localparam int HW  = mbe_pkg::HALF_W;
  localparam int PPW = 2 * HW;
  localparam int PRW = mbe_pkg::PROD_W;
  localparam int SAT_LSB = mbe_pkg::FRAC_W + mbe_pkg::MAG_W;

  logic [HW-1:0]  a_op;
  logic [HW-1:0]  b_op;
  logic [PPW-1:0] pp_r;
  logic [1:0]     pp_part_r;
  logic           pp_vld_r;
  logic [PRW-1:0] acc_r;
  logic [PRW-1:0] pp_ext;

  // Pick the halves for this partial product
  always_comb begin
    case (ctl.part)
      mbe_pkg::PART_LL: begin
        a_op = a_mag[HW-1:0];
        b_op = b_mag[HW-1:0];
      end
      mbe_pkg::PART_LH: begin
        a_op = a_mag[HW-1:0];
        b_op = b_mag[PPW-1:HW];
      end
      mbe_pkg::PART_HL: begin
        a_op = a_mag[PPW-1:HW];
        b_op = b_mag[HW-1:0];
      end
      default: begin
        a_op = a_mag[PPW-1:HW];
        b_op = b_mag[PPW-1:HW];
      end
    endcase
  end

  // Align the registered partial product
  always_comb begin
    case (pp_part_r) inside
      mbe_pkg::PART_LL: pp_ext = {{(PRW-PPW){1'b0}}, pp_r};
      mbe_pkg::PART_LH, mbe_pkg::PART_HL:
        pp_ext = {{(PRW-PPW-HW){1'b0}}, pp_r, {HW{1'b0}}};
      default: pp_ext = {pp_r, {(PRW-PPW){1'b0}}};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else if (ctl.clear) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= ctl.issue;
    end
  end

  // Multiply one pair of halves and accumulate the previous one
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      pp_r      <= a_op * b_op;
      pp_part_r <= ctl.part;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= acc_r + pp_ext;
    end
  end

  // Drop the fraction bits and saturate the magnitude
  assign prod_sat = (acc_r[PRW-1:SAT_LSB] != '0) ? mbe_pkg::MAG_MAX
                                                : acc_r[SAT_LSB-1:mbe_pkg::FRAC_W];

endmodule

// ----- src/mbe_back.sv -----
module mbe_back #(
  parameter int ITER_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  mbe_pkg::cpoint_t          q_head,
  output logic                      q_pop,
  input  logic [ITER_BITS-1:0]      max_iter,
  input  logic [mbe_pkg::Q_W-1:0]   esc_rad_sq,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ITER_BITS-1:0]      out_iteration_count
);

  localparam int QW = mbe_pkg::Q_W;
  localparam int MW = mbe_pkg::MAG_W;
  localparam int SW = mbe_pkg::SUM_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_STEP = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_LOAD       = 3'd0;
  localparam logic [PH_W-1:0] PH_ISSUE_LAST = 3'd4;
  localparam logic [PH_W-1:0] PH_LAST       = 3'd5;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [PH_W-1:0]      phase_r;
  logic [ITER_BITS-1:0] count_r;
  mbe_pkg::q_t          cr_r;
  mbe_pkg::q_t          ci_r;
  mbe_pkg::q_t          zr_r;
  mbe_pkg::q_t          zi_r;
  mbe_pkg::q_t          xy_r;
  logic [MW-1:0]        xx_r;
  logic [MW-1:0]        yy_r;
  logic [QW-1:0]        mr_r;
  logic [QW-1:0]        mi_r;
  logic                 neg_r;
  logic                 out_valid_r;
  logic [ITER_BITS-1:0] out_count_r;

  mbe_pkg::mul_ctl_t    ctl;
  logic [MW-1:0]        sat_xx;
  logic [MW-1:0]        sat_yy;
  logic [MW-1:0]        sat_xy;
  logic [MW-1:0]        xy_dbl;
  mbe_pkg::q_t          xy_mag;
  logic [QW-1:0]        m2;
  logic                 done;
  logic                 out_free;
  logic signed [SW-1:0] zr_sum;
  logic signed [SW-1:0] zi_sum;
  mbe_pkg::q_t          zr_nxt;
  mbe_pkg::q_t          zi_nxt;

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_free            = !out_valid_r || !out_stall;
  assign q_pop               = (state_r == ST_IDLE) && !q_empty;

  // Drive the three product units from one shared control word
  always_comb begin
    ctl.clear = (state_r == ST_MUL) && (phase_r == PH_LOAD);
    ctl.issue = (state_r == ST_MUL) && (phase_r != PH_LOAD) && (phase_r <= PH_ISSUE_LAST);
    ctl.part  = 2'(phase_r - 3'd1);
  end

  mbe_qmul u_mul_xx (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .a_mag    (mr_r),
    .b_mag    (mr_r),
    .prod_sat (sat_xx)
  );

  mbe_qmul u_mul_yy (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .a_mag    (mi_r),
    .b_mag    (mi_r),
    .prod_sat (sat_yy)
  );

  mbe_qmul u_mul_xy (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .a_mag    (mr_r),
    .b_mag    (mi_r),
    .prod_sat (sat_xy)
  );

  // Escape test on the last z and the next z from the stored squares
  always_comb begin
    m2     = {1'b0, xx_r} + {1'b0, yy_r};
    done   = (m2 > esc_rad_sq) || (count_r == max_iter);
    zr_sum = $signed({{(SW-MW){1'b0}}, xx_r}) - $signed({{(SW-MW){1'b0}}, yy_r})
           + $signed({{(SW-QW){cr_r[QW-1]}}, cr_r});
    zi_sum = $signed({{(SW-QW){xy_r[QW-1]}}, xy_r})
           + $signed({{(SW-QW){ci_r[QW-1]}}, ci_r});
    zr_nxt = mbe_pkg::sat_q(zr_sum);
    zi_nxt = mbe_pkg::sat_q(zi_sum);
    xy_dbl = sat_xy[MW-1] ? mbe_pkg::MAG_MAX : {sat_xy[MW-2:0], 1'b0};
    xy_mag = {1'b0, xy_dbl};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (!done) begin
          state_nxt = ST_MUL;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (phase_r == PH_LAST) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT:  state_nxt = ST_STEP;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_MUL) begin
        phase_r <= PH_W'(phase_r + 1'b1);
      end else begin
        phase_r <= PH_LOAD;
      end
      if ((state_r == ST_STEP) && done && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Iteration datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cr_r    <= q_head.cr;
        ci_r    <= q_head.ci;
        count_r <= '0;
        xx_r    <= '0;
        yy_r    <= '0;
        xy_r    <= '0;
      end
      ST_STEP: begin
        if (done) begin
          if (out_free) begin
            out_count_r <= count_r;
          end
        end else begin
          count_r <= ITER_BITS'(count_r + 1'b1);
          zr_r    <= zr_nxt;
          zi_r    <= zi_nxt;
        end
      end
      ST_MUL: begin
        if (phase_r == PH_LOAD) begin
          mr_r  <= mbe_pkg::mag_q(zr_r);
          mi_r  <= mbe_pkg::mag_q(zi_r);
          neg_r <= zr_r[QW-1] ^ zi_r[QW-1];
        end
      end
      ST_SAT: begin
        xx_r <= sat_xx;
        yy_r <= sat_yy;
        xy_r <= neg_r ? -xy_mag : xy_mag;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/mandelbrot_escape_time.sv -----
// Channel  Handshake                      Payload
// ------   -----------------------------  --------------------------------------
// in       in_valid / in_stall            in_column, in_row
// out      out_valid / out_stall          out_iteration_count
// cfg      psel, penable, pwrite, pready  paddr (8 bytes per register), pwdata, prdata
//
// Each iteration of a pixel runs an update step, then a multiply phase in which each of
// three 24x24 multipliers works through the four partial products of one 48-bit square
// or cross product, then a saturation step. A new pixel is taken while the previous
// one iterates, through a two-entry queue of mapped points. Reset is synchronous and
// leaves the registers at their default view. A stalled result holds the iteration
// engine; the front keeps accepting until the queue and its holding register are full.
module mandelbrot_escape_time #(
  parameter int COORD_BITS = 12,
  parameter int ITER_BITS  = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [COORD_BITS-1:0]             in_column,
  input  logic [COORD_BITS-1:0]             in_row,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ITER_BITS-1:0]              out_iteration_count,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mbe_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mbe_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mbe_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int QW = mbe_pkg::Q_W;
  localparam int SW = mbe_pkg::STEP_W;
  localparam int DW = mbe_pkg::APB_DATA_W;

  localparam logic [QW-1:0]        X_MIN_RST  = 48'hFFFE_0000_0000;
  localparam logic [SW-1:0]        STEP_RST   = 47'h0000_00C0_0000;
  localparam logic [QW-1:0]        Y_MAX_RST  = 48'h0001_8000_0000;
  localparam logic [QW-1:0]        ESC_RST    = 48'h0004_0000_0000;
  localparam logic [ITER_BITS-1:0] MAX_IT_RST = ITER_BITS'(256);

  mbe_pkg::coord_cfg_t              coord_r;
  logic [ITER_BITS-1:0]             max_iter_r;
  logic [QW-1:0]                    esc_rsq_r;
  logic [mbe_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                             cfg_wr;

  logic                             q_push;
  mbe_pkg::cpoint_t                 q_push_data;
  logic                             q_full;
  logic                             q_pop;
  mbe_pkg::cpoint_t                 q_head;
  logic                             q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mbe_pkg::APB_ADDR_W-1:mbe_pkg::REG_LSB];
  assign cfg_wr  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r.x_min  <= X_MIN_RST;
      coord_r.x_step <= STEP_RST;
      coord_r.y_max  <= Y_MAX_RST;
      coord_r.y_step <= STEP_RST;
      max_iter_r     <= MAX_IT_RST;
      esc_rsq_r      <= ESC_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mbe_pkg::REG_X_MIN:    coord_r.x_min  <= pwdata[QW-1:0];
        mbe_pkg::REG_X_STEP:   coord_r.x_step <= pwdata[SW-1:0];
        mbe_pkg::REG_Y_MAX:    coord_r.y_max  <= pwdata[QW-1:0];
        mbe_pkg::REG_Y_STEP:   coord_r.y_step <= pwdata[SW-1:0];
        mbe_pkg::REG_MAX_ITER: max_iter_r     <= pwdata[ITER_BITS-1:0];
        mbe_pkg::REG_ESC_RSQ:  esc_rsq_r      <= pwdata[QW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      mbe_pkg::REG_X_MIN:    prdata = {{(DW-QW){1'b0}}, coord_r.x_min};
      mbe_pkg::REG_X_STEP:   prdata = {{(DW-SW){1'b0}}, coord_r.x_step};
      mbe_pkg::REG_Y_MAX:    prdata = {{(DW-QW){1'b0}}, coord_r.y_max};
      mbe_pkg::REG_Y_STEP:   prdata = {{(DW-SW){1'b0}}, coord_r.y_step};
      mbe_pkg::REG_MAX_ITER: prdata = {{(DW-ITER_BITS){1'b0}}, max_iter_r};
      mbe_pkg::REG_ESC_RSQ:  prdata = {{(DW-QW){1'b0}}, esc_rsq_r};
      default:               prdata = '0;
    endcase
  end

  mbe_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_column (in_column),
    .in_row    (in_row),
    .cfg       (coord_r),
    .push      (q_push),
    .push_data (q_push_data),
    .q_full    (q_full)
  );

  mbe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mbe_back #(
    .ITER_BITS (ITER_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .max_iter            (max_iter_r),
    .esc_rad_sq          (esc_rsq_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int COORD_BITS = 12;
  localparam int ITER_BITS  = 14;

  localparam longint          ONE_Q = 64'sd1 <<< 32;
  localparam longint          Q_HI  = 64'sh7FFF_FFFF_FFFF;
  localparam longint          Q_LO  = -64'sh8000_0000_0000;
  localparam longint unsigned M47   = 64'h7FFF_FFFF_FFFF;
  localparam longint unsigned M48   = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned LIM48 = 64'h1_0000_0000_0000;

  typedef struct {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_t;

  typedef struct {
    pixel_t               pix;
    logic [ITER_BITS-1:0] count;
  } escape_rec_t;

  logic                                clk;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  logic [COORD_BITS-1:0]               in_column = '0;
  logic [COORD_BITS-1:0]               in_row    = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [ITER_BITS-1:0]                out_iteration_count;
  logic                                psel      = 1'b0;
  logic                                penable   = 1'b0;
  logic                                pwrite    = 1'b0;
  logic [mbe_pkg::APB_ADDR_W-1:0]      paddr     = '0;
  logic [mbe_pkg::APB_DATA_W-1:0]      pwdata    = '0;
  logic [mbe_pkg::APB_DATA_W-1:0]      prdata;
  logic                                pready;

  // Mirror of the register file, starting at the reset view
  mbe_pkg::q_t                  view_x_min    = -48'sd8589934592;
  logic [mbe_pkg::STEP_W-1:0]   view_x_step   = 47'd12582912;
  mbe_pkg::q_t                  view_y_max    = 48'sd6442450944;
  logic [mbe_pkg::STEP_W-1:0]   view_y_step   = 47'd12582912;
  logic [ITER_BITS-1:0]         view_max_iter = 14'd256;
  logic [mbe_pkg::Q_W-1:0]      view_esc_rsq  = 48'd17179869184;

  pixel_t      pixel_queue[$];
  escape_rec_t expected_counts[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int results_seen   = 0;
  int limit_hits     = 0;
  int first_escapes  = 0;
  int views_applied  = 0;

  mandelbrot_escape_time #(
    .COORD_BITS(COORD_BITS),
    .ITER_BITS (ITER_BITS)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_iteration_count(out_iteration_count),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  // Clamp a wide sum into the Q16.32 range
  function automatic mbe_pkg::q_t clamp_q(input longint v);
    if (v > Q_HI) begin
      return mbe_pkg::q_t'(Q_HI);
    end else if (v < Q_LO) begin
      return mbe_pkg::q_t'(Q_LO);
    end
    return mbe_pkg::q_t'(v);
  endfunction

  // Fixed-point product: magnitudes multiplied, truncated, saturated, then signed
  function automatic mbe_pkg::q_t fx_mul(input mbe_pkg::q_t a, input mbe_pkg::q_t b,
                                         input bit twice);
    longint          sa;
    longint          sb;
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned m;
    logic [95:0]     prod;
    logic            neg;
    sa   = a;
    sb   = b;
    neg  = a[mbe_pkg::Q_W-1] ^ b[mbe_pkg::Q_W-1];
    ma   = (sa < 0) ? -sa : sa;
    mb   = (sb < 0) ? -sb : sb;
    prod = 96'(ma) * 96'(mb);
    m    = prod[95:32];
    if (m > M47) m = M47;
    if (twice) begin
      m = m << 1;
      if (m > M47) m = M47;
    end
    return neg ? mbe_pkg::q_t'(-longint'(m)) : mbe_pkg::q_t'(m);
  endfunction

  // Map the pixel and iterate z = z*z + c until escape or the limit
  function automatic logic [ITER_BITS-1:0] escape_count(input pixel_t p);
    longint unsigned px;
    longint unsigned py;
    longint unsigned m2;
    mbe_pkg::q_t     cr;
    mbe_pkg::q_t     ci;
    mbe_pkg::q_t     zr;
    mbe_pkg::q_t     zi;
    mbe_pkg::q_t     xx;
    mbe_pkg::q_t     yy;
    mbe_pkg::q_t     xy2;
    int unsigned     n;
    px = 64'(p.column) * 64'(view_x_step);
    py = 64'(p.row) * 64'(view_y_step);
    if (px > LIM48) px = LIM48;
    if (py > LIM48) py = LIM48;
    cr = clamp_q(longint'(view_x_min) + longint'(px));
    ci = clamp_q(longint'(view_y_max) - longint'(py));
    zr = '0;
    zi = '0;
    n  = 0;
    while (n < view_max_iter) begin
      xx  = fx_mul(zr, zr, 1'b0);
      yy  = fx_mul(zi, zi, 1'b0);
      xy2 = fx_mul(zr, zi, 1'b1);
      n++;
      zr = clamp_q(longint'(xx) - longint'(yy) + longint'(cr));
      zi = clamp_q(longint'(xy2) + longint'(ci));
      m2 = {16'b0, fx_mul(zr, zr, 1'b0)} + {16'b0, fx_mul(zi, zi, 1'b0)};
      if (m2 > {16'b0, view_esc_rsq}) break;
    end
    return ITER_BITS'(n);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Drive the next pixel once the current transaction is taken
  always @(posedge clk) begin : drive_pixels
    pixel_t pix;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pix       = pixel_queue.pop_front();
        in_valid  <= 1'b1;
        in_column <= pix.column;
        in_row    <= pix.row;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Predict on every accepted pixel, check every accepted count
  always @(posedge clk) begin : watch_counts
    escape_rec_t rec;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        rec.pix.column = in_column;
        rec.pix.row    = in_row;
        rec.count      = escape_count(rec.pix);
        if (rec.count == view_max_iter) limit_hits++;
        if (rec.count == 1) first_escapes++;
        expected_counts.push_back(rec);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("count %0d arrived with no pixel pending",
                                    out_iteration_count));
        end else begin
          rec = expected_counts.pop_front();
          if (out_iteration_count !== rec.count) begin
            report_mismatch($sformatf("pixel (%0d,%0d) count %0d, predicted %0d",
                                      rec.pix.column, rec.pix.row,
                                      out_iteration_count, rec.count));
          end
        end
      end
    end
  end

  // Write one register through setup and access cycles
  task automatic write_reg(input logic [mbe_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] word);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mbe_pkg::APB_ADDR_W'(idx) << mbe_pkg::REG_LSB;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      mbe_pkg::REG_X_MIN:    view_x_min    = word[mbe_pkg::Q_W-1:0];
      mbe_pkg::REG_X_STEP:   view_x_step   = word[mbe_pkg::STEP_W-1:0];
      mbe_pkg::REG_Y_MAX:    view_y_max    = word[mbe_pkg::Q_W-1:0];
      mbe_pkg::REG_Y_STEP:   view_y_step   = word[mbe_pkg::STEP_W-1:0];
      mbe_pkg::REG_MAX_ITER: view_max_iter = word[ITER_BITS-1:0];
      mbe_pkg::REG_ESC_RSQ:  view_esc_rsq  = word[mbe_pkg::Q_W-1:0];
      default: ;
    endcase
  endtask

  // Fill the bits above a register's width with noise when asked
  function automatic logic [63:0] pad_word(input logic [63:0] value, input int width,
                                           input bit junk);
    logic [63:0] mask;
    mask = (64'd1 << width) - 1;
    return (value & mask) | (junk ? ({$urandom, $urandom} & ~mask) : 64'd0);
  endfunction

  task automatic set_view(input longint x_min, input longint unsigned x_step,
                          input longint y_max, input longint unsigned y_step,
                          input int unsigned iters, input longint unsigned rsq,
                          input bit junk);
    write_reg(mbe_pkg::REG_X_MIN,    pad_word(x_min,  mbe_pkg::Q_W,    junk));
    write_reg(mbe_pkg::REG_X_STEP,   pad_word(x_step, mbe_pkg::STEP_W, junk));
    write_reg(mbe_pkg::REG_Y_MAX,    pad_word(y_max,  mbe_pkg::Q_W,    junk));
    write_reg(mbe_pkg::REG_Y_STEP,   pad_word(y_step, mbe_pkg::STEP_W, junk));
    write_reg(mbe_pkg::REG_MAX_ITER, pad_word(64'(iters), ITER_BITS,   junk));
    write_reg(mbe_pkg::REG_ESC_RSQ,  pad_word(rsq,    mbe_pkg::Q_W,    junk));
    views_applied++;
  endtask

  task automatic queue_pixel(input int c, input int r);
    pixel_t p;
    p.column = COORD_BITS'(c);
    p.row    = COORD_BITS'(r);
    pixel_queue.push_back(p);
  endtask

  // Hold until every queued pixel has been counted
  task automatic wait_drained();
    @(negedge clk);
    while (pixel_queue.size() > 0 || in_valid || expected_counts.size() > 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int              win;
    int              n_items;
    bit              wild;
    longint          x0;
    longint          y0;
    longint unsigned sx;
    longint unsigned sy;
    longint unsigned rsq;
    send_idle_pct  = 37;
    recv_stall_pct = 49;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset view: corners, points inside the set, fast escapes
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(683, 512);
    queue_pixel(512, 512);
    queue_pixel(1023, 0);
    queue_pixel(2048, 2048);
    wait_drained();

    // c = 0 everywhere with the largest limit: one pixel runs to the end
    set_view(0, 0, 0, 0, 16383, 4 * ONE_Q, 1'b0);
    @(negedge clk);
    queue_pixel(0, 0);
    wait_drained();

    // Extreme coordinates and steps: sums and squares saturate, threshold never met
    set_view(Q_LO, M47, Q_HI, M47, 5, M48, 1'b1);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(1, 1);
    queue_pixel(2, 2);
    queue_pixel(4095, 0);
    wait_drained();

    // Zero threshold: any nonzero magnitude escapes at once
    set_view(0, 64'd1 << 16, 0, 0, 3, 0, 1'b0);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(1, 0);
    queue_pixel(0, 4095);
    wait_drained();

    // Zero limit: no step is taken
    set_view(-2 * ONE_Q, 12582912, 3 * ONE_Q / 2, 12582912, 0, 4 * ONE_Q, 1'b0);
    @(negedge clk);
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    queue_pixel(700, 300);
    wait_drained();

    // Random views: mostly windows over the set, some arbitrary register values
    for (int stage = 0; stage < 3; stage++) begin
      send_idle_pct  = (stage == 0) ? 37 : (stage == 1) ? 49 : 0;
      recv_stall_pct = (stage == 0) ? 49 : (stage == 1) ? 37 : 0;
      for (int v = 0; v < 4; v++) begin
        wild = ($urandom_range(0, 3) == 0);
        win  = $urandom_range(3, 10);
        if (wild) begin
          x0  = longint'({$urandom, $urandom} << 16) >>> 16;
          y0  = longint'({$urandom, $urandom} << 16) >>> 16;
          sx  = ({$urandom, $urandom} & M47) >> $urandom_range(0, 46);
          sy  = ({$urandom, $urandom} & M47) >> $urandom_range(0, 46);
          rsq = ({$urandom, $urandom} & M48) >> $urandom_range(0, 47);
          set_view(x0, sx, y0, sy, $urandom_range(0, 24), rsq, 1'b1);
        end else begin
          x0  = -9 * ONE_Q / 4 + longint'($urandom);
          y0  = 3 * ONE_Q / 2 + longint'($urandom_range(0, 1 << 30)) - (64'sd1 << 29);
          sx  = ((3 * ONE_Q) >> win) + $urandom_range(0, 255);
          sy  = ((3 * ONE_Q) >> win) + $urandom_range(0, 255);
          rsq = $urandom_range(0, 1) ? 4 * ONE_Q
                                     : (longint'($urandom_range(0, 15)) << 32) | $urandom;
          set_view(x0, sx, y0, sy, $urandom_range(1, 40), rsq, 1'b0);
        end
        n_items = 120;
        @(negedge clk);
        for (int i = 0; i < n_items; i++) begin
          // Let the pipeline run dry once per stage before going on
          if (v == 0 && i == n_items / 2) wait_drained();
          if (!wild && $urandom_range(0, 99) < 85) begin
            queue_pixel($urandom_range(0, (1 << win) - 1), $urandom_range(0, (1 << win) - 1));
          end else begin
            queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
          end
        end
        wait_drained();
      end
    end

    // Give a stray result time to show up
    repeat (40) @(posedge clk);
    $display("Checked %0d escape counts across %0d register views.",
             results_seen, views_applied);
    $display("%0d pixels ran to the iteration limit, %0d escaped on the first step.",
             limit_hits, first_escapes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
